/* hw/rtl/ket_pkg.sv */
// Shared types and constants for the keyed expiry timer table.
package ket_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int VAL_W    = 32;
    localparam int HDL_W    = 16;
    localparam int STEP_W   = 16;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd1;
    localparam logic [VAL_W-1:0]  COUNT_MIN  = 32'h8000_0000;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;
    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_FAIL    = 1'b1;

    typedef logic [KEY_BITS-1:0] t_key;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_action                action;
        logic [31:0]            key;
        logic signed [VAL_W-1:0] expire_value;
        logic [HDL_W-1:0]       handle;
    } t_cmd;

    typedef struct packed {
        logic             kind;
        logic             status;
        logic [31:0]      out_key;
        logic [HDL_W-1:0] out_handle;
        logic             last;
    } t_res;

endpackage

/* hw/rtl/ket_ram.sv */
// Generic simple dual-port RAM with registered read.
module ket_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/keyed_expiry_timer_table.sv */
// Keyed expiry timer table: top level with walk sequencer and entry storage.
//
// Commands enter on i_cmd and are taken at a clock edge where start is high
// and busy is low. Start, update and stop each give one status result; tick
// gives one timeout result per expired entry, in slot order, and none when
// nothing expires. The last result of a command has last set.
// Results appear on o_res for one cycle with o_res_valid high; the receiver
// cannot hold them off, and at most one result leaves per cycle.
// From acceptance until busy drops, one key comparator and one saturating
// subtractor walk the 16 slots one per cycle through the single read port
// of the entry RAMs, whose read data is registered before it is examined;
// then a closing state, ST_DONE, commits start, update or stop and
// releases the final result. The final result shows in the first cycle
// after busy falls; earlier timeouts of a tick show while busy is high.
// The tick_step register is written over the cfg channel (always ready) and
// should only change while busy is low. Reset empties the table, sets
// tick_step to 1 and drops any result in flight.
module keyed_expiry_timer_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  ket_pkg::t_cmd                  i_cmd,
    output logic                           busy,
    output logic                           o_res_valid,
    output ket_pkg::t_res                  o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ket_pkg::STEP_W-1:0]     i_cfg_data
);

    ket_pkg::t_state                  r_state, n_state;
    ket_pkg::t_cmd                    r_cmd;
    logic [ket_pkg::CNT_W-1:0]        r_rd_idx, n_rd_idx;
    logic                             r_rd_vld, n_rd_vld;
    logic [ket_pkg::IDX_W-1:0]        r_proc_idx, n_proc_idx;
    logic [ket_pkg::ENTRIES-1:0]      r_valid, n_valid;
    logic                             r_found, n_found;
    logic [ket_pkg::IDX_W-1:0]        r_found_idx, n_found_idx;
    logic                             r_free, n_free;
    logic [ket_pkg::IDX_W-1:0]        r_free_idx, n_free_idx;
    logic                             r_pend, n_pend;
    ket_pkg::t_key                    r_pend_key, n_pend_key;
    logic [ket_pkg::HDL_W-1:0]        r_pend_handle, n_pend_handle;
    logic                             r_res_vld, n_res_vld;
    ket_pkg::t_res                    r_res, n_res;
    logic [ket_pkg::STEP_W-1:0]       r_tick_step;

    logic [ket_pkg::IDX_W-1:0]        rd_addr;
    logic [ket_pkg::IDX_W-1:0]        wr_addr;
    logic                             key_we, cnt_we, hdl_we;
    logic [ket_pkg::VAL_W-1:0]        cnt_wdata;
    ket_pkg::t_key                    key_q;
    logic [ket_pkg::VAL_W-1:0]        cnt_q;
    logic [ket_pkg::HDL_W-1:0]        hdl_q;

    ket_pkg::t_key                    cmd_key;
    logic signed [ket_pkg::VAL_W:0]   diff;
    logic [ket_pkg::VAL_W-1:0]        sat_cnt;
    logic                             expired;
    logic                             slot_live;

    ket_ram #(.WIDTH(ket_pkg::KEY_BITS), .DEPTH(ket_pkg::ENTRIES)) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (key_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (cmd_key),
        .i_rd_addr (rd_addr),
        .o_rd_data (key_q)
    );

    ket_ram #(.WIDTH(ket_pkg::VAL_W), .DEPTH(ket_pkg::ENTRIES)) u_cnt_ram (
        .i_clk     (i_clk),
        .i_we      (cnt_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (cnt_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (cnt_q)
    );

    ket_ram #(.WIDTH(ket_pkg::HDL_W), .DEPTH(ket_pkg::ENTRIES)) u_hdl_ram (
        .i_clk     (i_clk),
        .i_we      (hdl_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_cmd.handle),
        .i_rd_addr (rd_addr),
        .o_rd_data (hdl_q)
    );

    assign cmd_key   = ket_pkg::t_key'(r_cmd.key);
    assign slot_live = r_valid[r_proc_idx];
    assign expired   = cnt_q[ket_pkg::VAL_W-1] || (cnt_q == '0);

    // Shared subtractor: lower the count, clamp at the most negative value.
    assign diff    = $signed({cnt_q[ket_pkg::VAL_W-1], cnt_q})
                   - $signed({{(ket_pkg::VAL_W + 1 - ket_pkg::STEP_W){1'b0}}, r_tick_step});
    assign sat_cnt = (diff[ket_pkg::VAL_W] != diff[ket_pkg::VAL_W-1])
                   ? ket_pkg::COUNT_MIN : diff[ket_pkg::VAL_W-1:0];

    always_comb begin
        n_state       = r_state;
        n_rd_idx      = r_rd_idx;
        n_rd_vld      = 1'b0;
        n_proc_idx    = r_proc_idx;
        n_valid       = r_valid;
        n_found       = r_found;
        n_found_idx   = r_found_idx;
        n_free        = r_free;
        n_free_idx    = r_free_idx;
        n_pend        = r_pend;
        n_pend_key    = r_pend_key;
        n_pend_handle = r_pend_handle;
        n_res_vld     = 1'b0;
        n_res         = r_res;
        rd_addr       = r_rd_idx[ket_pkg::IDX_W-1:0];
        wr_addr       = r_proc_idx;
        key_we        = 1'b0;
        cnt_we        = 1'b0;
        hdl_we        = 1'b0;
        cnt_wdata     = sat_cnt;

        case (r_state)
            ket_pkg::ST_IDLE: begin
                n_rd_idx = '0;
                n_found  = 1'b0;
                n_free   = 1'b0;
                n_pend   = 1'b0;
                if (start) begin
                    n_state = ket_pkg::ST_WALK;
                end
            end

            ket_pkg::ST_WALK: begin
                // Issue the next slot read.
                if (r_rd_idx < ket_pkg::CNT_W'(ket_pkg::ENTRIES)) begin
                    n_rd_idx   = r_rd_idx + ket_pkg::CNT_W'(1);
                    n_rd_vld   = 1'b1;
                    n_proc_idx = rd_addr;
                end
                // Examine the slot read in the previous cycle.
                if (r_rd_vld) begin
                    if (r_cmd.action == ket_pkg::ACT_TICK) begin
                        if (slot_live) begin
                            if (expired) begin
                                n_valid[r_proc_idx] = 1'b0;
                                // Release the held timeout; it is not the last one.
                                if (r_pend) begin
                                    n_res_vld        = 1'b1;
                                    n_res.kind       = ket_pkg::KIND_TIMEOUT;
                                    n_res.status     = ket_pkg::STAT_OK;
                                    n_res.out_key    = 32'(r_pend_key);
                                    n_res.out_handle = r_pend_handle;
                                    n_res.last       = 1'b0;
                                end
                                n_pend        = 1'b1;
                                n_pend_key    = key_q;
                                n_pend_handle = hdl_q;
                            end else begin
                                cnt_we = 1'b1;
                            end
                        end
                    end else begin
                        if (slot_live && (key_q == cmd_key) && !r_found) begin
                            n_found     = 1'b1;
                            n_found_idx = r_proc_idx;
                        end
                        if (!slot_live && !r_free) begin
                            n_free     = 1'b1;
                            n_free_idx = r_proc_idx;
                        end
                    end
                    if (r_proc_idx == ket_pkg::IDX_W'(ket_pkg::ENTRIES - 1)) begin
                        n_state = ket_pkg::ST_DONE;
                    end
                end
            end

            ket_pkg::ST_DONE: begin
                n_state   = ket_pkg::ST_IDLE;
                cnt_wdata = r_cmd.expire_value;
                if (r_cmd.action == ket_pkg::ACT_TICK) begin
                    if (r_pend) begin
                        n_res_vld        = 1'b1;
                        n_res.kind       = ket_pkg::KIND_TIMEOUT;
                        n_res.status     = ket_pkg::STAT_OK;
                        n_res.out_key    = 32'(r_pend_key);
                        n_res.out_handle = r_pend_handle;
                        n_res.last       = 1'b1;
                    end
                end else begin
                    n_res_vld        = 1'b1;
                    n_res.kind       = ket_pkg::KIND_STATUS;
                    n_res.status     = ket_pkg::STAT_FAIL;
                    n_res.out_key    = 32'(cmd_key);
                    n_res.out_handle = '0;
                    n_res.last       = 1'b1;
                    case (r_cmd.action)
                        ket_pkg::ACT_START: begin
                            if (!r_found && r_free) begin
                                wr_addr             = r_free_idx;
                                key_we              = 1'b1;
                                cnt_we              = 1'b1;
                                hdl_we              = 1'b1;
                                n_valid[r_free_idx] = 1'b1;
                                n_res.status        = ket_pkg::STAT_OK;
                            end
                        end
                        ket_pkg::ACT_UPDATE: begin
                            if (r_found) begin
                                wr_addr      = r_found_idx;
                                cnt_we       = 1'b1;
                                n_res.status = ket_pkg::STAT_OK;
                            end
                        end
                        ket_pkg::ACT_STOP: begin
                            if (r_found) begin
                                n_valid[r_found_idx] = 1'b0;
                                n_res.status         = ket_pkg::STAT_OK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            default: begin
                n_state = ket_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ket_pkg::ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_rd_idx    <= '0;
            r_valid     <= '0;
            r_found     <= 1'b0;
            r_free      <= 1'b0;
            r_pend      <= 1'b0;
            r_res_vld   <= 1'b0;
            r_tick_step <= ket_pkg::STEP_RESET;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_rd_idx  <= n_rd_idx;
            r_valid   <= n_valid;
            r_found   <= n_found;
            r_free    <= n_free;
            r_pend    <= n_pend;
            r_res_vld <= n_res_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tick_step <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        r_proc_idx    <= n_proc_idx;
        r_found_idx   <= n_found_idx;
        r_free_idx    <= n_free_idx;
        r_pend_key    <= n_pend_key;
        r_pend_handle <= n_pend_handle;
        r_res         <= n_res;
    end

    assign busy        = (r_state != ket_pkg::ST_IDLE);
    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

/* hw/rtl/ket_chk.sv */
// Port-level checker for the keyed expiry timer table, bound to the top level.
module ket_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_res_valid,
    input ket_pkg::t_res              o_res
);

    // An accepted command keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted command");

    // Results only come from work that was in progress in the previous cycle.
    a_res_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result without a command in progress");

    // A result that is not the last one leaves while the command still runs.
    a_more_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> busy)
        else $error("non-final result after the command finished");

    // A status result closes its command and carries no handle.
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == ket_pkg::KIND_STATUS))
            |-> (o_res.last && (o_res.out_handle == '0)))
        else $error("status result not final or with a handle");

    // After the final result of a command nothing follows in the next cycle.
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("result right after a final result");

endmodule

bind keyed_expiry_timer_table ket_chk u_ket_chk (.*);

/* bench/tb_top.sv */
// Self-checking bench for the keyed expiry timer table: driver, monitor, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 30;
    localparam int POOL_SIZE   = 20;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 90;
    localparam int SHOW_MAX    = 10;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    ket_pkg::t_cmd              i_cmd;
    logic                       busy;
    logic                       o_res_valid;
    ket_pkg::t_res              o_res;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [ket_pkg::STEP_W-1:0] i_cfg_data;

    keyed_expiry_timer_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the timer table and the step register
    bit                               slot_live   [ket_pkg::ENTRIES];
    logic [31:0]                      slot_key    [ket_pkg::ENTRIES];
    logic signed [ket_pkg::VAL_W-1:0] slot_count  [ket_pkg::ENTRIES];
    logic [ket_pkg::HDL_W-1:0]        slot_handle [ket_pkg::ENTRIES];
    logic [ket_pkg::STEP_W-1:0]       step_shadow;

    ket_pkg::t_cmd cmd_backlog[$];
    ket_pkg::t_res pending_results[$];
    logic [31:0]   key_pool[POOL_SIZE];

    int mismatches;
    int cycles;
    bit took;
    int burst_left;
    int gap_left;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic ket_pkg::t_res status_result(logic fail, logic [31:0] k);
        ket_pkg::t_res r;
        r.kind       = ket_pkg::KIND_STATUS;
        r.status     = fail;
        r.out_key    = k;
        r.out_handle = '0;
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic void apply_command(ket_pkg::t_cmd c);
        ket_pkg::t_res held;
        bit            have_held;
        int            hit;
        int            free_slot;
        longint        lowered;
        hit       = -1;
        free_slot = -1;
        have_held = 1'b0;
        if (c.action == ket_pkg::ACT_TICK) begin
            for (int i = 0; i < ket_pkg::ENTRIES; i++) begin
                if (slot_live[i]) begin
                    if (slot_count[i] <= 0) begin
                        // Hold the previous timeout so only the final one carries last
                        if (have_held) pending_results.push_back(held);
                        held.kind       = ket_pkg::KIND_TIMEOUT;
                        held.status     = ket_pkg::STAT_OK;
                        held.out_key    = slot_key[i];
                        held.out_handle = slot_handle[i];
                        held.last       = 1'b0;
                        have_held       = 1'b1;
                        slot_live[i]    = 1'b0;
                    end else begin
                        lowered = longint'(slot_count[i]) - longint'(step_shadow);
                        if (lowered < -64'sd2147483648) lowered = -64'sd2147483648;
                        slot_count[i] = lowered[31:0];
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                pending_results.push_back(held);
            end
        end else begin
            for (int i = ket_pkg::ENTRIES - 1; i >= 0; i--) begin
                if (slot_live[i] && slot_key[i] == c.key) hit = i;
                if (!slot_live[i]) free_slot = i;
            end
            if (c.action == ket_pkg::ACT_START) begin
                if (hit >= 0 || free_slot < 0) begin
                    pending_results.push_back(status_result(ket_pkg::STAT_FAIL, c.key));
                end else begin
                    slot_live[free_slot]   = 1'b1;
                    slot_key[free_slot]    = c.key;
                    slot_count[free_slot]  = c.expire_value;
                    slot_handle[free_slot] = c.handle;
                    pending_results.push_back(status_result(ket_pkg::STAT_OK, c.key));
                end
            end else if (hit < 0) begin
                pending_results.push_back(status_result(ket_pkg::STAT_FAIL, c.key));
            end else begin
                if (c.action == ket_pkg::ACT_UPDATE) slot_count[hit] = c.expire_value;
                else slot_live[hit] = 1'b0;
                pending_results.push_back(status_result(ket_pkg::STAT_OK, c.key));
            end
        end
    endfunction

    function automatic ket_pkg::t_cmd make_cmd(ket_pkg::t_action a, logic [31:0] k,
                                               logic [31:0] v,
                                               logic [ket_pkg::HDL_W-1:0] h);
        ket_pkg::t_cmd c;
        c.action       = a;
        c.key          = k;
        c.expire_value = v;
        c.handle       = h;
        return c;
    endfunction

    function automatic ket_pkg::t_cmd random_cmd();
        ket_pkg::t_action a;
        logic [31:0]      k;
        logic [31:0]      v;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)      a = ket_pkg::ACT_START;
        else if (pick < 55) a = ket_pkg::ACT_UPDATE;
        else if (pick < 70) a = ket_pkg::ACT_STOP;
        else                a = ket_pkg::ACT_TICK;
        // Mostly pool keys so hits, duplicates and a full table all occur
        if ($urandom_range(0, 9) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 50)      v = $urandom_range(0, 15);
        else if (pick < 65) v = -$urandom_range(1, 20);
        else if (pick < 80) v = $urandom;
        else if (pick < 85) v = 32'h8000_0000;
        else if (pick < 90) v = 32'h7fff_ffff;
        else                v = $urandom_range(16, 200000);
        return make_cmd(a, k, v, ket_pkg::HDL_W'($urandom));
    endfunction

    // Monitor: check results, then record accepted commands and register writes
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("keyed_expiry_timer_table verification failed");
            $finish;
        end else begin
            took = 1'b0;
            if (i_rst_n) begin
                if (o_res_valid) begin
                    if (pending_results.size() == 0) begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX)
                            $display("unexpected result %0b %0b %h %h %0b",
                                     o_res.kind, o_res.status, o_res.out_key,
                                     o_res.out_handle, o_res.last);
                    end else begin
                        ket_pkg::t_res want;
                        want = pending_results.pop_front();
                        if (o_res.kind !== want.kind || o_res.status !== want.status ||
                            o_res.out_key !== want.out_key ||
                            o_res.out_handle !== want.out_handle ||
                            o_res.last !== want.last) begin
                            mismatches++;
                            if (mismatches <= SHOW_MAX)
                                $display("mismatch exp %0b %0b %h %h %0b act %0b %0b %h %h %0b",
                                         want.kind, want.status, want.out_key,
                                         want.out_handle, want.last, o_res.kind,
                                         o_res.status, o_res.out_key, o_res.out_handle,
                                         o_res.last);
                        end
                    end
                end
                if (start && !busy) begin
                    took = 1'b1;
                    apply_command(i_cmd);
                end
                if (i_cfg_valid && o_cfg_ready) step_shadow = i_cfg_data;
            end
        end
    end

    // Driver: bursts of commands separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (cmd_backlog.size() > 0) begin
                i_cmd <= cmd_backlog.pop_front();
                start <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || start || busy || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tick_step(logic [ket_pkg::STEP_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [ket_pkg::STEP_W-1:0] steps[PHASES];
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        step_shadow = ket_pkg::STEP_RESET;
        mismatches  = 0;
        cycles      = 0;
        took        = 1'b0;
        burst_left  = $urandom_range(1, 30);
        gap_left    = 0;
        for (int i = 0; i < ket_pkg::ENTRIES; i++) slot_live[i] = 1'b0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        // Directed: quiet tick, missing keys, duplicate, full table, mass expiry
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_TICK, 32'h0, 32'h0, 16'h0));
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_STOP, 32'h0, 32'h0, 16'h0));
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_UPDATE, 32'hffff_ffff, 32'h5, 16'h0));
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_START, 32'h0, 32'h8000_0000, 16'hffff));
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_START, 32'hffff_ffff, 32'h7fff_ffff,
                                       16'h0));
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_START, 32'h0, 32'h3, 16'h1234));
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_UPDATE, 32'hffff_ffff, 32'h1, 16'h0));
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_TICK, 32'h0, 32'h0, 16'h0));
        for (int i = 0; i < ket_pkg::ENTRIES - 1; i++)
            cmd_backlog.push_back(make_cmd(ket_pkg::ACT_START, $urandom,
                                           -$urandom_range(0, 3),
                                           ket_pkg::HDL_W'($urandom)));
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_START, 32'h1357_9bdf, 32'h1, 16'h0));
        cmd_backlog.push_back(make_cmd(ket_pkg::ACT_TICK, 32'h0, 32'h0, 16'h0));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        steps[0] = '0;
        steps[1] = '1;
        steps[2] = ket_pkg::STEP_W'($urandom_range(0, 65535));
        steps[3] = ket_pkg::STEP_RESET;
        steps[4] = ket_pkg::STEP_W'($urandom_range(2, 6));
        for (int p = 0; p < PHASES; p++) begin
            write_tick_step(steps[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) cmd_backlog.push_back(random_cmd());
            wait_idle();
        end

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("keyed_expiry_timer_table verification clean");
        end else begin
            $display("keyed_expiry_timer_table verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ket_pkg.sv
hw/rtl/ket_ram.sv
hw/rtl/keyed_expiry_timer_table.sv
hw/rtl/ket_chk.sv
bench/tb_top.sv
